FILE: rtl/core/rsf_pkg.sv
// Shared types and constants of the range sample filter.
package rsf_pkg;

	localparam int DIST_W     = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] DOWN_INDEX = 2'd3;
	localparam logic [7:0] RUN_MAX    = 8'd255;
	localparam logic [6:0] ALPHA_FULL = 7'd100;

	// (raw + 5) / 10 as a multiply by a reciprocal, exact for 17-bit operands
	localparam logic [16:0] ROUND_MM      = 17'd5;
	localparam logic [16:0] RECIP10       = 17'd104858;
	localparam int          RECIP10_SHIFT = 20;

	// x / 100 as a multiply by a reciprocal, exact for 20-bit operands
	localparam logic [20:0] RECIP100       = 21'd1342178;
	localparam int          RECIP100_SHIFT = 27;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [15:0]       RST_MIN_VALID_MM      = 16'd40;
	localparam logic [15:0]       RST_MAX_VALID_MM      = 16'd4000;
	localparam logic [7:0]        RST_FAIL_LIMIT        = 8'd3;
	localparam logic [6:0]        RST_ALPHA_PERCENT     = 7'd50;
	localparam logic [DIST_W-1:0] RST_DOWN_NO_TARGET_CM = 13'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_VALID_MM,
		REG_MAX_VALID_MM,
		REG_FAIL_LIMIT,
		REG_ALPHA_PERCENT,
		REG_DOWN_NO_TARGET_CM
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  sensor_index;
		logic        sensor_ok;
		logic        timed_out;
		logic [15:0] raw_mm;
	} in_t;

	typedef struct packed {
		logic [1:0]        out_sensor_index;
		logic [DIST_W-1:0] distance_cm;
		logic              reading_valid;
		logic              frame_any_valid;
	} out_t;

	typedef struct packed {
		logic [15:0]       min_valid_mm;
		logic [15:0]       max_valid_mm;
		logic [7:0]        fail_limit;
		logic [6:0]        alpha_percent;
		logic [DIST_W-1:0] down_no_target_cm;
	} cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [1:0]        sensor_index;
		logic              has_sensor;
		logic              valid;
		logic [DIST_W-1:0] cm;
	} cls_t;

endpackage

FILE: rtl/core/rsf_front.sv
// Front end: validates a reading and converts it to centimeters.
module rsf_front #(
	parameter int SENSOR_COUNT = 4
) (
	input  rsf_pkg::cfg_t cfg,
	input  rsf_pkg::in_t  item,
	output rsf_pkg::cls_t cls
);
	import rsf_pkg::*;

	logic        ok;
	logic        is_down;
	logic        no_target;
	logic        in_window;
	logic        has_sensor;
	logic [16:0] rounded;
	logic [33:0] scaled;

	assign ok         = item.sensor_ok & ~item.timed_out;
	assign is_down    = (item.sensor_index == DOWN_INDEX);
	assign has_sensor = (int'(item.sensor_index) < SENSOR_COUNT);

	// downward sensor: nothing in range reads as zero or anywhere past the window
	assign no_target = ok & is_down &
		((item.raw_mm == 16'd0) | (item.raw_mm > cfg.max_valid_mm));
	assign in_window = ok & (item.raw_mm >= cfg.min_valid_mm) &
		(item.raw_mm <= cfg.max_valid_mm);

	assign rounded = {1'b0, item.raw_mm} + ROUND_MM;
	assign scaled  = 34'(rounded) * 34'(RECIP10);

	always_comb begin
		cls.sensor_index = item.sensor_index;
		cls.has_sensor   = has_sensor;
		cls.valid        = (no_target | in_window) & has_sensor;
		cls.cm           = no_target ? cfg.down_no_target_cm
			: scaled[RECIP10_SHIFT +: DIST_W];
	end

endmodule

FILE: rtl/core/rsf_queue.sv
// Short queue of classified requests between front and back.
module rsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rsf_pkg::cls_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output rsf_pkg::cls_t rd_data,
	output logic          empty
);
	import rsf_pkg::*;

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/rsf_back.sv
// Back end: per-sensor average, failure runs, frame flag and result buffer.
module rsf_back #(
	parameter int SENSOR_COUNT   = 4,
	parameter int GROUND_BASE_CM = 100,
	parameter int FALLBACK_CM    = 400
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rsf_pkg::cfg_t cfg,
	input  rsf_pkg::cls_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output rsf_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);
	import rsf_pkg::*;

	localparam logic [DIST_W-1:0] FALLBACK   = DIST_W'(FALLBACK_CM);
	localparam logic [DIST_W-1:0] GROUND     = DIST_W'(GROUND_BASE_CM);
	localparam int                DOWN_ENTRY = int'(DOWN_INDEX);

	// per-sensor state
	logic [DIST_W-1:0] avg_q [SENSOR_COUNT];
	logic [7:0]        run_q [SENSOR_COUNT];
	logic              frame_seen_q;

	// stage 1: weighted sum or final distance
	logic              vld_s1;
	logic [1:0]        idx_s1;
	logic              upd_s1;
	logic [19:0]       sum_s1;
	logic [DIST_W-1:0] dist_s1;
	logic              frame_s1;

	// result buffer
	out_t       ob_q [2];
	logic       ob_wr_q;
	logic       ob_rd_q;
	logic [1:0] ob_cnt_q;
	logic       ob_full;
	logic       ob_pop;

	logic [DIST_W-1:0] avg_rd;
	logic [7:0]        run_rd;
	logic [7:0]        run_inc;
	logic [6:0]        a_sat;
	logic [6:0]        inv_a;
	logic [19:0]       sum_a;
	logic [DIST_W-1:0] dist_a;
	logic              is_down;
	logic              frame_a;
	logic              hazard;
	logic              s1_move;
	logic              take;
	logic [40:0]       scaled_b;
	logic [DIST_W-1:0] avg_new;
	out_t              res_b;

	always_comb begin
		avg_rd = '0;
		run_rd = '0;
		for (int e = 0; e < SENSOR_COUNT; e++) begin
			if (int'(head.sensor_index) == e) begin
				avg_rd = avg_rd | avg_q[e];
				run_rd = run_rd | run_q[e];
			end
		end
	end

	assign a_sat   = (cfg.alpha_percent > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha_percent;
	assign inv_a   = ALPHA_FULL - a_sat;
	assign sum_a   = 20'(avg_rd) * 20'(inv_a) + 20'(head.cm) * 20'(a_sat);
	assign run_inc = (run_rd == RUN_MAX) ? run_rd : run_rd + 8'd1;
	assign dist_a  = (!head.has_sensor || run_inc >= cfg.fail_limit) ? FALLBACK : avg_rd;
	assign is_down = (head.sensor_index == DOWN_INDEX);
	assign frame_a = is_down & (frame_seen_q | head.valid);

	// average of this sensor still being written back
	assign hazard  = vld_s1 & upd_s1 & (idx_s1 == head.sensor_index);
	assign ob_full = (ob_cnt_q == 2'd2);
	assign s1_move = vld_s1 & ~ob_full;
	assign take    = ~q_empty & ~hazard & (~vld_s1 | s1_move);
	assign q_pop   = take;

	assign scaled_b = 41'(sum_s1) * 41'(RECIP100);
	assign avg_new  = scaled_b[RECIP100_SHIFT +: DIST_W];

	always_comb begin
		res_b.out_sensor_index = idx_s1;
		res_b.distance_cm      = upd_s1 ? avg_new : dist_s1;
		res_b.reading_valid    = upd_s1;
		res_b.frame_any_valid  = frame_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < SENSOR_COUNT; e++) begin
				avg_q[e] <= (e == DOWN_ENTRY) ? GROUND : FALLBACK;
				run_q[e] <= '0;
			end
			frame_seen_q <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			if (take) begin
				for (int e = 0; e < SENSOR_COUNT; e++) begin
					if (int'(head.sensor_index) == e) begin
						run_q[e] <= head.valid ? 8'd0 : run_inc;
					end
				end
				frame_seen_q <= is_down ? 1'b0 : (frame_seen_q | head.valid);
			end
			if (s1_move && upd_s1) begin
				for (int e = 0; e < SENSOR_COUNT; e++) begin
					if (int'(idx_s1) == e) begin
						avg_q[e] <= avg_new;
					end
				end
			end
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_s1   <= head.sensor_index;
			upd_s1   <= head.valid;
			sum_s1   <= sum_a;
			dist_s1  <= dist_a;
			frame_s1 <= frame_a;
		end
	end

	assign empty  = (ob_cnt_q == 2'd0);
	assign ob_pop = pop & ~empty;
	assign result = ob_q[ob_rd_q];

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ob_q[ob_wr_q] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (s1_move) begin
				ob_wr_q <= ~ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= ~ob_rd_q;
			end
			case ({s1_move, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/range_sample_filter_with_dropout_hold.sv
// Range sample filter with dropout hold: top level, registers and wiring.
//
// Input side is a queue: a reading request (sensor index, ok and timeout
// flags, raw millimeters) is taken at a clock edge with push high and full
// low. Result side is a queue too: the oldest result sits on result while
// empty is low and is taken at an edge with pop high.
// Registers are written through cfg_we / cfg_index / cfg_data, one per cycle;
// the user must write them only while no request is in flight, which the
// block does not enforce; unknown indexes are ignored. A taken request passes
// the request queue, stage 1 and the result buffer before it is on result.
// One request per cycle is sustained while the result buffer has room. A valid
// reading followed directly by any request for the same sensor stalls that request:
// the new average is written back before that sensor's average is read again.
// Reset loads the register defaults, sets every average to the fallback
// distance (the downward sensor to its ground base), clears failure runs
// and the frame flag, and empties both queues.
// If the receiver stalls, a two-entry result buffer fills, then the back end
// holds, the four-entry request queue fills and full rises.
module range_sample_filter_with_dropout_hold #(
	parameter int SENSOR_COUNT   = 4,
	parameter int GROUND_BASE_CM = 100,
	parameter int FALLBACK_CM    = 400
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  rsf_pkg::in_t                     item,
	output logic                             empty,
	input  logic                             pop,
	output rsf_pkg::out_t                    result,
	input  logic                             cfg_we,
	input  logic [rsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rsf_pkg::*;

	cfg_t cfg_q;
	cls_t cls;
	cls_t head;
	logic q_empty;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_valid_mm      <= RST_MIN_VALID_MM;
			cfg_q.max_valid_mm      <= RST_MAX_VALID_MM;
			cfg_q.fail_limit        <= RST_FAIL_LIMIT;
			cfg_q.alpha_percent     <= RST_ALPHA_PERCENT;
			cfg_q.down_no_target_cm <= RST_DOWN_NO_TARGET_CM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_VALID_MM:      cfg_q.min_valid_mm      <= cfg_data;
				REG_MAX_VALID_MM:      cfg_q.max_valid_mm      <= cfg_data;
				REG_FAIL_LIMIT:        cfg_q.fail_limit        <= cfg_data[7:0];
				REG_ALPHA_PERCENT:     cfg_q.alpha_percent     <= cfg_data[6:0];
				REG_DOWN_NO_TARGET_CM: cfg_q.down_no_target_cm <= cfg_data[DIST_W-1:0];
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	rsf_front #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_front (
		.cfg  (cfg_q),
		.item (item),
		.cls  (cls)
	);

	rsf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push & ~full),
		.wr_data (cls),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	rsf_back #(
		.SENSOR_COUNT   (SENSOR_COUNT),
		.GROUND_BASE_CM (GROUND_BASE_CM),
		.FALLBACK_CM    (FALLBACK_CM)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

FILE: tb/tb_range_sample_filter_with_dropout_hold.sv
// Self-checking testbench of the range sample filter with dropout hold.
module tb_range_sample_filter_with_dropout_hold;
	timeunit 1ns;
	timeprecision 1ps;

	import rsf_pkg::*;

	localparam int SENSOR_COUNT   = 4;
	localparam int GROUND_BASE_CM = 100;
	localparam int FALLBACK_CM    = 400;

	// Tracks filter state per sensor and holds the expected results in order.
	class range_filter_scoreboard;
		cfg_t              regs;
		logic [DIST_W-1:0] average_cm [SENSOR_COUNT];
		logic [7:0]        failure_run [SENSOR_COUNT];
		logic              frame_seen;
		out_t              pending_results [$];
		int                mismatches;

		function new();
			regs.min_valid_mm      = RST_MIN_VALID_MM;
			regs.max_valid_mm      = RST_MAX_VALID_MM;
			regs.fail_limit        = RST_FAIL_LIMIT;
			regs.alpha_percent     = RST_ALPHA_PERCENT;
			regs.down_no_target_cm = RST_DOWN_NO_TARGET_CM;
			for (int s = 0; s < SENSOR_COUNT; s++) begin
				average_cm[s]  = DIST_W'(FALLBACK_CM);
				failure_run[s] = 8'd0;
			end
			average_cm[DOWN_INDEX] = DIST_W'(GROUND_BASE_CM);
			frame_seen = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MIN_VALID_MM:      regs.min_valid_mm = value;
				REG_MAX_VALID_MM:      regs.max_valid_mm = value;
				REG_FAIL_LIMIT:        regs.fail_limit = value[7:0];
				REG_ALPHA_PERCENT:     regs.alpha_percent = value[6:0];
				REG_DOWN_NO_TARGET_CM: regs.down_no_target_cm = value[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		function out_t filter_reading(in_t r);
			out_t        res;
			logic        ok;
			logic        valid;
			int unsigned cm;
			int unsigned a;
			int unsigned raw;
			int unsigned idx;
			idx   = r.sensor_index;
			raw   = r.raw_mm;
			ok    = r.sensor_ok && !r.timed_out;
			valid = 1'b0;
			cm    = 0;
			// downward sensor: nothing in range counts as the no-target distance
			if (ok && r.sensor_index == DOWN_INDEX && (raw == 0 || raw > regs.max_valid_mm)) begin
				cm    = regs.down_no_target_cm;
				valid = 1'b1;
			end else if (ok && raw >= regs.min_valid_mm && raw <= regs.max_valid_mm) begin
				cm    = (raw + 5) / 10;
				valid = 1'b1;
			end
			res.out_sensor_index = r.sensor_index;
			res.reading_valid    = valid;
			if (valid) begin
				a = (regs.alpha_percent > ALPHA_FULL) ? ALPHA_FULL : regs.alpha_percent;
				failure_run[idx] = 8'd0;
				average_cm[idx]  = DIST_W'((average_cm[idx] * (100 - a) + cm * a) / 100);
				res.distance_cm  = average_cm[idx];
			end else begin
				if (failure_run[idx] != RUN_MAX)
					failure_run[idx] = failure_run[idx] + 8'd1;
				res.distance_cm = (failure_run[idx] >= regs.fail_limit) ?
					DIST_W'(FALLBACK_CM) : average_cm[idx];
			end
			if (r.sensor_index == DOWN_INDEX) begin
				res.frame_any_valid = frame_seen || valid;
				frame_seen = 1'b0;
			end else begin
				res.frame_any_valid = 1'b0;
				frame_seen = frame_seen || valid;
			end
			return res;
		endfunction

		function void note_request(in_t r);
			pending_results.push_back(filter_reading(r));
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending_results.size() == 0) begin
				$error("result popped with no request pending");
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("out_sensor_index", want.out_sensor_index, got.out_sensor_index);
			compare_field("distance_cm", want.distance_cm, got.distance_cm);
			compare_field("reading_valid", want.reading_valid, got.reading_valid);
			compare_field("frame_any_valid", want.frame_any_valid, got.frame_any_valid);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_t                   item;
	logic                  empty;
	logic                  pop;
	out_t                  result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	range_filter_scoreboard sb;
	bit tx_gaps;
	bit rx_stalls;
	int dropout_left [SENSOR_COUNT];

	range_sample_filter_with_dropout_hold dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic in_t reading(logic [1:0] idx, logic ok, logic to, logic [15:0] raw);
		in_t r;
		r.sensor_index = idx;
		r.sensor_ok    = ok;
		r.timed_out    = to;
		r.raw_mm       = raw;
		return r;
	endfunction

	// Mostly in-window readings, with edges, no-target values and full noise mixed in.
	function automatic in_t make_reading(logic [1:0] idx, bit force_fail);
		in_t         r;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		lo   = sb.regs.min_valid_mm;
		hi   = sb.regs.max_valid_mm;
		pick = $urandom_range(0, 99);
		r.sensor_index = idx;
		r.sensor_ok    = ($urandom_range(0, 9) != 0);
		r.timed_out    = ($urandom_range(0, 9) == 0);
		if (pick < 60 && lo <= hi)
			r.raw_mm = 16'($urandom_range(hi, lo));
		else if (pick < 70)
			r.raw_mm = (pick % 2) ? 16'd0 : 16'(hi + 1);
		else if (pick < 80) begin
			case (pick % 4)
				0: r.raw_mm = 16'(lo - 1);
				1: r.raw_mm = 16'(lo);
				2: r.raw_mm = 16'(hi);
				default: r.raw_mm = 16'(hi + 1);
			endcase
		end else
			r.raw_mm = 16'($urandom());
		if (force_fail) begin
			if ($urandom_range(0, 1))
				r.sensor_ok = 1'b0;
			else
				r.timed_out = 1'b1;
		end
		return r;
	endfunction

	task automatic send_reading(input in_t r);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = r;
		push = 1'b1;
		do @(posedge clk); while (full);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic send_sensor(input logic [1:0] idx);
		bit fail;
		fail = 1'b0;
		if (dropout_left[idx] == 0 && $urandom_range(0, 19) == 0)
			dropout_left[idx] = $urandom_range(1, 10);
		if (dropout_left[idx] > 0) begin
			dropout_left[idx]--;
			fail = 1'b1;
		end
		send_reading(make_reading(idx, fail));
	endtask

	// Mostly whole frames (front, left, right, down), sometimes a lone stray index.
	task automatic run_frames(input int n);
		int sent;
		sent = 0;
		tx_gaps   = ($urandom_range(0, 3) != 0);
		rx_stalls = ($urandom_range(0, 3) != 0);
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_sensor(2'($urandom_range(0, 3)));
				sent++;
			end else begin
				for (int s = 0; s < SENSOR_COUNT; s++)
					send_sensor(2'(s));
				sent += SENSOR_COUNT;
			end
		end
		push = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// registers change only once every request has been answered
	task automatic configure(input int lo, input int hi, input int limit, input int alpha,
			input int down_cm);
		push = 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		write_reg(REG_MIN_VALID_MM, CFG_DATA_W'(lo));
		write_reg(REG_MAX_VALID_MM, CFG_DATA_W'(hi));
		write_reg(REG_FAIL_LIMIT, CFG_DATA_W'(limit));
		write_reg(REG_ALPHA_PERCENT, CFG_DATA_W'(alpha));
		write_reg(REG_DOWN_NO_TARGET_CM, CFG_DATA_W'(down_cm));
	endtask

	initial begin : result_drain
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_stalls ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(result);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int lo;
		int hi;
		sb        = new();
		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		for (int s = 0; s < SENSOR_COUNT; s++)
			dropout_left[s] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: window edges, failure flags, dropout into fallback, down no-target
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'd40));
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'd4000));
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'd39));
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'd4001));
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'hFFFF));
		send_reading(reading(2'd1, 1'b0, 1'b0, 16'd500));
		send_reading(reading(2'd1, 1'b1, 1'b1, 16'd500));
		send_reading(reading(2'd1, 1'b0, 1'b1, 16'd500));
		send_reading(reading(2'd1, 1'b1, 1'b0, 16'd0));
		send_reading(reading(2'd1, 1'b1, 1'b0, 16'd1234));
		send_reading(reading(2'd2, 1'b1, 1'b0, 16'd2000));
		send_reading(reading(2'd3, 1'b1, 1'b0, 16'd0));
		send_reading(reading(2'd3, 1'b1, 1'b0, 16'd4001));
		send_reading(reading(2'd3, 1'b1, 1'b0, 16'hFFFF));
		send_reading(reading(2'd3, 1'b0, 1'b0, 16'd0));
		send_reading(reading(2'd3, 1'b1, 1'b1, 16'd4001));
		send_reading(reading(2'd0, 1'b1, 1'b0, 16'd2345));
		send_reading(reading(2'd1, 1'b1, 1'b0, 16'd777));
		send_reading(reading(2'd2, 1'b1, 1'b0, 16'd3999));
		send_reading(reading(2'd3, 1'b1, 1'b0, 16'd1500));
		send_reading(reading(2'd0, 1'b0, 1'b0, 16'd100));
		send_reading(reading(2'd1, 1'b1, 1'b1, 16'd100));
		send_reading(reading(2'd2, 1'b1, 1'b0, 16'd10));
		send_reading(reading(2'd3, 1'b0, 1'b0, 16'd100));
		push = 1'b0;

		// widest window, average frozen, fallback on the first failure
		configure(0, 65535, 1, 0, 0);
		run_frames(40);

		// empty window, fail limit zero, alpha past full scale
		configure(65535, 0, 0, 127, 8191);
		run_frames(40);

		// long dropout on one sensor drives its failure run into saturation
		configure(40, 4000, 255, 100, 400);
		tx_gaps = 1'b0;
		for (int k = 0; k < 300; k++)
			send_reading(make_reading(2'd1, 1'b1));
		send_reading(reading(2'd1, 1'b1, 1'b0, 16'd1000));
		run_frames(20);

		for (int p = 0; p < 6; p++) begin
			if (p == 3) begin
				lo = $urandom_range(3000, 65535);
				hi = $urandom_range(0, 2999);
			end else begin
				lo = $urandom_range(0, 500);
				hi = $urandom_range(1000, 65535);
			end
			configure(lo, hi, (p == 1) ? 0 : $urandom_range(1, 8), $urandom_range(0, 127),
				$urandom_range(0, 8191));
			run_frames(220);
		end

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
